// ===== hw/rtl/mcs_pkg.sv =====
// Shared types, constants and chord tables of the MIDI chord stacker.
// No dependencies; every other file of the block imports this package.
package mcs_pkg;

  localparam int unsigned MCS_NOTE_SLOTS   = 2048;
  localparam int unsigned MCS_QUEUE_DEPTH  = 4;
  localparam int unsigned MCS_CHORD_NOTES  = 6;
  localparam int unsigned MCS_SEL_W        = $clog2(MCS_CHORD_NOTES);

  localparam logic [2:0] MCS_EMPTY_TYPE = 3'd7;
  localparam logic [3:0] MIDI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON   = 4'h9;

  localparam logic [1:0] CFG_CHORD_TYPE = 2'd0;
  localparam logic [1:0] CFG_SPREAD     = 2'd1;
  localparam logic [1:0] CFG_BYPASS     = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ON,
    KIND_OFF
  } mcs_kind_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_CHORD
  } mcs_seq_e;

  // One classified message from the front end to the back end.
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [15:0] t;
    mcs_kind_e   kind;
    logic [2:0]  ctype;
  } mcs_cmd_t;

  // One message travelling down the back-end pipeline.
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [15:0] t;
    logic        gen_on;
    logic        last;
  } mcs_note_t;

  localparam logic signed [5:0] CHORD_OFS [8][MCS_CHORD_NOTES] = '{
    '{6'sd0,   6'sd0,   6'sd0,  6'sd0,  6'sd0, 6'sd0},
    '{-6'sd12, 6'sd12,  6'sd0,  6'sd0,  6'sd0, 6'sd0},
    '{6'sd4,   6'sd7,   6'sd12, 6'sd0,  6'sd0, 6'sd0},
    '{6'sd3,   6'sd7,   6'sd12, 6'sd0,  6'sd0, 6'sd0},
    '{6'sd7,   6'sd0,   6'sd0,  6'sd0,  6'sd0, 6'sd0},
    '{6'sd5,   6'sd7,   6'sd0,  6'sd0,  6'sd0, 6'sd0},
    '{-6'sd12, -6'sd24, 6'sd12, 6'sd24, 6'sd7, 6'sd19},
    '{6'sd0,   6'sd0,   6'sd0,  6'sd0,  6'sd0, 6'sd0}
  };

  localparam logic [2:0] CHORD_LEN [8] = '{
    3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd2, 3'd6, 3'd0
  };

  // Marks the chord offsets of a type whose note lands inside 0..127.
  function automatic logic [MCS_CHORD_NOTES-1:0] chord_mask(logic [2:0] ctype,
                                                            logic [6:0] root);
    logic [MCS_CHORD_NOTES-1:0] m;
    logic [8:0]                 nsum;
    logic [5:0]                 ofs;
    m = '0;
    for (int j = 0; j < MCS_CHORD_NOTES; j++) begin
      ofs  = CHORD_OFS[ctype][j];
      nsum = {2'b00, root} + {{3{ofs[5]}}, ofs};
      m[j] = (3'(j) < CHORD_LEN[ctype]) && !nsum[8] && !nsum[7];
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/mcs_front.sv =====
// Front end: accepts messages, classifies them and keeps the held-chord store.
// Depends on mcs_pkg. Feeds mcs_queue with classified commands.
module mcs_front #(
  parameter int unsigned NOTE_SLOTS = mcs_pkg::MCS_NOTE_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       status_byte_i,
  input  logic [6:0]       data_one_i,
  input  logic [6:0]       data_two_i,
  input  logic [15:0]      sample_time_i,
  input  logic [2:0]       chord_type_i,
  input  logic             bypass_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output mcs_pkg::mcs_cmd_t push_cmd_o
);
  import mcs_pkg::*;

  localparam int unsigned    AW        = $clog2(NOTE_SLOTS);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(NOTE_SLOTS - 1);
  localparam logic [11:0]    SLOTS_W   = 12'(NOTE_SLOTS);

  logic [2:0]    mem_q [NOTE_SLOTS];
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          s1_valid_q, s1_valid_d;
  mcs_cmd_t      s1_cmd_q;
  logic          s1_store_q;
  logic [AW-1:0] s1_addr_q;
  logic [2:0]    rd_q;
  logic          fwd_q;
  logic [2:0]    fwd_data_q;

  logic          accept;
  logic          s1_adv;
  logic [3:0]    hi;
  logic [10:0]   key;
  logic          key_in;
  mcs_kind_e     kind;
  logic [2:0]    held;
  logic [2:0]    ctype;
  logic          we;
  logic [AW-1:0] waddr;
  logic [2:0]    wdata;

  assign s1_adv     = s1_valid_q && push_ready_i;
  assign in_ready_o = !clr_q && (!s1_valid_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign hi     = status_byte_i[7:4];
  assign key    = {status_byte_i[3:0], data_one_i};
  assign key_in = {1'b0, key} < SLOTS_W;

  always_comb begin
    if (bypass_i) begin
      kind = KIND_PASS;
    end else if (hi == MIDI_NOTE_ON && data_two_i != 7'd0) begin
      kind = KIND_ON;
    end else if (hi == MIDI_NOTE_OFF || hi == MIDI_NOTE_ON) begin
      kind = KIND_OFF;
    end else begin
      kind = KIND_PASS;
    end
  end

  // The entry read for this item may have been written by the item ahead of it
  // in the very cycle of the read; that value was captured as a forward.
  assign held = fwd_q ? fwd_data_q : rd_q;

  always_comb begin
    ctype = chord_type_i;
    case (s1_cmd_q.kind)
      KIND_OFF: begin
        if (s1_store_q && held != MCS_EMPTY_TYPE) ctype = held;
      end
      default: ;
    endcase
  end

  always_comb begin
    push_cmd_o       = s1_cmd_q;
    push_cmd_o.ctype = ctype;
  end
  assign push_valid_o = s1_valid_q;

  always_comb begin
    we    = 1'b0;
    waddr = s1_addr_q;
    wdata = MCS_EMPTY_TYPE;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
    end else if (s1_adv && s1_store_q) begin
      case (s1_cmd_q.kind)
        KIND_ON: begin
          we    = 1'b1;
          wdata = (chord_type_i == MCS_EMPTY_TYPE) ? 3'd0 : chord_type_i;
        end
        KIND_OFF: begin
          we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST_ADDR) clr_d = 1'b0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q.status <= status_byte_i;
      s1_cmd_q.d1     <= data_one_i;
      s1_cmd_q.d2     <= data_two_i;
      s1_cmd_q.t      <= sample_time_i;
      s1_cmd_q.kind   <= kind;
      s1_cmd_q.ctype  <= chord_type_i;
      s1_store_q      <= key_in;
      s1_addr_q       <= key[AW-1:0];
      fwd_q           <= we && (waddr == key[AW-1:0]);
      fwd_data_q      <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (accept && key_in) rd_q <= mem_q[key[AW-1:0]];
  end

endmodule

// ===== hw/rtl/mcs_queue.sv =====
// Command queue that decouples the front end from the back end.
// Depends on mcs_pkg for the command type and the queue depth.
module mcs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  mcs_pkg::mcs_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output mcs_pkg::mcs_cmd_t pop_cmd_o
);
  import mcs_pkg::*;

  localparam int unsigned PW   = $clog2(MCS_QUEUE_DEPTH);
  localparam logic [PW:0] FULL = (PW + 1)'(MCS_QUEUE_DEPTH);

  mcs_cmd_t      buf_q [MCS_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = cnt_q != FULL;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// ===== hw/rtl/mcs_back.sv =====
// Back end: expands each command into its messages and computes jitter and
// velocity in a stalling pipeline ending in the output register. Uses mcs_pkg.
module mcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  mcs_pkg::mcs_cmd_t pop_cmd_i,
  input  logic [9:0]        spread_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_status_o,
  output logic [6:0]        out_data_one_o,
  output logic [6:0]        out_data_two_o,
  output logic [16:0]       out_time_o,
  output logic              last_of_run_o
);
  import mcs_pkg::*;

  logic en;

  // Sequencer.
  mcs_seq_e                   state_q, state_d;
  mcs_cmd_t                   ent_q, ent_d;
  logic [MCS_CHORD_NOTES-1:0] mask_q, mask_d;
  logic [MCS_CHORD_NOTES-1:0] head_mask, mask_rest;
  logic [MCS_SEL_W-1:0]       sel;
  logic [5:0]                 chord_ofs;
  logic                       iss_valid;
  mcs_note_t                  iss_note;
  logic [5:0]                 iss_ofs;

  // Pipeline.
  logic             a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, o_valid_q;
  mcs_note_t        a_note_q, b_note_q, c_note_q, d_note_q, e_note_q;
  logic [5:0]       a_ofs_q;
  logic [10:0]      b_v_q, c_v_q, b_v_d;
  logic [4:0]       c_quo_q, c_quo_d;
  logic [6:0]       d_r_q, d_r_d;
  logic [16:0]      e_jit_q, e_jit_d;
  logic [16:0]      e_mag_q, e_mag_d;
  logic             e_neg_q, e_neg_d;
  logic [7:0]       o_status_q, o_status_d;
  logic [6:0]       o_d1_q, o_d1_d;
  logic [6:0]       o_d2_q, o_d2_d;
  logic [16:0]      o_time_q, o_time_d;
  logic             o_last_q, o_last_d;

  logic signed [11:0] seed;
  logic [21:0]        quo_prod;
  logic [11:0]        hund;
  logic [7:0]         dev;
  logic [6:0]         mag;
  logic [16:0]        dq_prod;
  logic [6:0]         dq;
  logic signed [8:0]  vsum;
  logic [6:0]         vel_clamped;

  assign en = !o_valid_q || out_ready_i;

  assign head_mask = chord_mask(pop_cmd_i.ctype, pop_cmd_i.d1);

  always_comb begin
    sel = '0;
    for (int j = MCS_CHORD_NOTES - 1; j >= 0; j--) begin
      if (mask_q[j]) sel = MCS_SEL_W'(j);
    end
  end
  assign mask_rest = mask_q & ~(MCS_CHORD_NOTES'(1) << sel);
  assign chord_ofs = CHORD_OFS[ent_q.ctype][sel];

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (pop_ready_o && pop_valid_i && pop_cmd_i.kind != KIND_PASS &&
            head_mask != '0) begin
          state_d = SEQ_CHORD;
        end
      end
      SEQ_CHORD: begin
        if (en && mask_rest == '0) state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    iss_valid   = 1'b0;
    iss_note    = '0;
    iss_ofs     = '0;
    ent_d       = ent_q;
    mask_d      = mask_q;
    case (state_q)
      SEQ_IDLE: begin
        pop_ready_o = en;
        if (en && pop_valid_i) begin
          // The incoming message always goes out first, unchanged.
          iss_valid       = 1'b1;
          iss_note.status = pop_cmd_i.status;
          iss_note.note   = pop_cmd_i.d1;
          iss_note.vel    = pop_cmd_i.d2;
          iss_note.t      = pop_cmd_i.t;
          iss_note.last   = (pop_cmd_i.kind == KIND_PASS) || (head_mask == '0);
          ent_d           = pop_cmd_i;
          mask_d          = head_mask;
        end
      end
      SEQ_CHORD: begin
        if (en) begin
          iss_valid       = 1'b1;
          iss_note.status = {(ent_q.kind == KIND_ON) ? MIDI_NOTE_ON : MIDI_NOTE_OFF,
                             ent_q.status[3:0]};
          iss_note.note   = ent_q.d1 + {chord_ofs[5], chord_ofs};
          iss_note.vel    = (ent_q.kind == KIND_ON) ? ent_q.d2 : 7'd0;
          iss_note.t      = ent_q.t;
          iss_note.gen_on = ent_q.kind == KIND_ON;
          iss_note.last   = mask_rest == '0;
          iss_ofs         = chord_ofs;
          mask_d          = mask_rest;
        end
      end
      default: ;
    endcase
  end

  // Seed of the pseudo-random value, brought to a non-negative number with
  // the same remainder modulo 100 as its 16-bit two's complement form.
  always_comb begin
    seed  = $signed({5'b00000, a_note_q.note}) * 12'sd13 +
            $signed({{6{a_ofs_q[5]}}, a_ofs_q}) * 12'sd7;
    b_v_d = seed[11] ? 11'(seed + 12'sd236) : seed[10:0];
  end

  // Quotient by 100 through a reciprocal, exact for values below 2048.
  assign quo_prod = 22'(b_v_q) * 22'd1311;
  assign c_quo_d  = quo_prod[21:17];

  assign hund  = 12'(c_quo_q) * 12'd100;
  assign d_r_d = 7'(12'(c_v_q) - hund);

  always_comb begin
    dev     = {d_r_q, 1'b0} - 8'd100;
    e_neg_d = dev[7];
    mag     = e_neg_d ? 7'(-dev) : dev[6:0];
    e_jit_d = 17'(d_r_q) * 17'(spread_i);
    e_mag_d = 17'(mag) * 17'(spread_i);
  end

  // Division by 1280 is a shift by 8 and then a reciprocal divide by 5.
  always_comb begin
    dq_prod = 17'(e_mag_q[16:8]) * 17'd205;
    dq      = dq_prod[16:10];
    if (e_neg_q) begin
      vsum = $signed({2'b00, e_note_q.vel}) - $signed({2'b00, dq});
    end else begin
      vsum = $signed({2'b00, e_note_q.vel}) + $signed({2'b00, dq});
    end
    if (vsum < 9'sd1) begin
      vel_clamped = 7'd1;
    end else if (vsum > 9'sd127) begin
      vel_clamped = 7'd127;
    end else begin
      vel_clamped = vsum[6:0];
    end
    o_status_d = e_note_q.status;
    o_d1_d     = e_note_q.note;
    o_d2_d     = e_note_q.gen_on ? vel_clamped : e_note_q.vel;
    o_time_d   = e_note_q.gen_on ? {1'b0, e_note_q.t} + 17'(e_jit_q[16:8])
                                 : {1'b0, e_note_q.t};
    o_last_d   = e_note_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (en) begin
        a_valid_q <= iss_valid;
        b_valid_q <= a_valid_q;
        c_valid_q <= b_valid_q;
        d_valid_q <= c_valid_q;
        e_valid_q <= d_valid_q;
        o_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    mask_q <= mask_d;
    if (en) begin
      a_note_q   <= iss_note;
      a_ofs_q    <= iss_ofs;
      b_note_q   <= a_note_q;
      b_v_q      <= b_v_d;
      c_note_q   <= b_note_q;
      c_v_q      <= b_v_q;
      c_quo_q    <= c_quo_d;
      d_note_q   <= c_note_q;
      d_r_q      <= d_r_d;
      e_note_q   <= d_note_q;
      e_jit_q    <= e_jit_d;
      e_mag_q    <= e_mag_d;
      e_neg_q    <= e_neg_d;
      o_status_q <= o_status_d;
      o_d1_q     <= o_d1_d;
      o_d2_q     <= o_d2_d;
      o_time_q   <= o_time_d;
      o_last_q   <= o_last_d;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign out_status_o   = o_status_q;
  assign out_data_one_o = o_d1_q;
  assign out_data_two_o = o_d2_q;
  assign out_time_o     = o_time_q;
  assign last_of_run_o  = o_last_q;

endmodule

// ===== hw/rtl/midi_chord_stacker_top.sv =====
// MIDI chord stacker: each message in is passed on; unless bypassed, note-ons gain
// the notes of the selected chord and note-offs those of the chord held for their key.
// The input channel takes one message (status, two data bytes, sample time)
// per transaction; the output channel gives one message per transaction, with
// last_of_run set on the final message caused by an input.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// After reset the held-chord store is swept to empty, one entry per cycle, over all
// NOTE_SLOTS entries; in_ready_o stays low during the sweep.
// The first message of an input passes the front stage, the queue and the
// five-stage arithmetic pipeline before it reaches the output register.
// The sequencer issues each input and then its n chord notes that fall inside 0..127
// (0 to 6), and takes no new input until the last of them has been issued.
// When the receiver stalls, the output register and the pipeline behind it hold
// and the four-entry queue absorbs further inputs until it fills.
// Depends on mcs_pkg, mcs_front, mcs_queue and mcs_back.
module midi_chord_stacker_top #(
  parameter int unsigned NOTE_SLOTS = mcs_pkg::MCS_NOTE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,
  input  logic [15:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_status_o,
  output logic [6:0]  out_data_one_o,
  output logic [6:0]  out_data_two_o,
  output logic [16:0] out_time_o,
  output logic        last_of_run_o
);
  import mcs_pkg::*;

  logic [2:0] chord_type_q, chord_type_d;
  logic [9:0] spread_q, spread_d;
  logic       bypass_q, bypass_d;

  logic       push_valid, push_ready;
  mcs_cmd_t   push_cmd;
  logic       pop_valid, pop_ready;
  mcs_cmd_t   pop_cmd;

  always_comb begin
    chord_type_d = chord_type_q;
    spread_d     = spread_q;
    bypass_d     = bypass_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHORD_TYPE: chord_type_d = cfg_wdata_i[2:0];
        CFG_SPREAD:     spread_d     = cfg_wdata_i;
        CFG_BYPASS:     bypass_d     = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_type_q <= 3'd0;
      spread_q     <= 10'd0;
      bypass_q     <= 1'b0;
    end else begin
      chord_type_q <= chord_type_d;
      spread_q     <= spread_d;
      bypass_q     <= bypass_d;
    end
  end

  mcs_front #(
    .NOTE_SLOTS(NOTE_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .status_byte_i(status_byte_i),
    .data_one_i   (data_one_i),
    .data_two_i   (data_two_i),
    .sample_time_i(sample_time_i),
    .chord_type_i (chord_type_q),
    .bypass_i     (bypass_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  mcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  mcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_cmd_i     (pop_cmd),
    .spread_i      (spread_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_status_o  (out_status_o),
    .out_data_one_o(out_data_one_o),
    .out_data_two_o(out_data_two_o),
    .out_time_o    (out_time_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hw/rtl/mcs_checker.sv =====
// Port-level checks of the MIDI chord stacker, bound to its top level.
// Depends on mcs_pkg and on midi_chord_stacker_top for the bind.
module mcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [9:0]  cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  status_byte_i,
  input logic [6:0]  data_one_i,
  input logic [6:0]  data_two_i,
  input logic [15:0] sample_time_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_status_o,
  input logic [6:0]  out_data_one_o,
  input logic [6:0]  out_data_two_o,
  input logic [16:0] out_time_o,
  input logic        last_of_run_o
);
  import mcs_pkg::*;

  // The store sweep starts at reset, so no input can be taken right after it.
  ap_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_ready_o)
    else $error("input accepted before the store sweep finished");

  ap_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped without a transaction");

  ap_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_status_o) && $stable(out_data_one_o) &&
      $stable(out_data_two_o) && $stable(out_time_o) && $stable(last_of_run_o))
    else $error("stalled output changed");

  // Only generated note-ons carry jitter past the 16-bit time range, and their
  // velocity is clamped to at least one.
  ap_jitter_on_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_time_o[16] |->
      (out_status_o[7:4] == MIDI_NOTE_ON) && (out_data_two_o != 7'd0))
    else $error("time beyond 16 bits on a message that is not a generated note-on");

endmodule

bind midi_chord_stacker_top mcs_checker u_mcs_checker (.*);

// ===== test/mcs_stack_checker.sv =====
// Checker for the MIDI chord stacker: watches the register port and both
// message channels, predicts every output message and compares it.
// Depends on mcs_pkg for the note status codes and register indexes.
module mcs_stack_checker #(
  parameter int unsigned NOTE_SLOTS = mcs_pkg::MCS_NOTE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,
  input  logic [15:0] sample_time_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_status_i,
  input  logic [6:0]  out_data_one_i,
  input  logic [6:0]  out_data_two_i,
  input  logic [16:0] out_time_i,
  input  logic        last_of_run_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mcs_pkg::*;

  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [16:0] stamp;
    logic        last;
  } midi_msg_t;

  localparam int CHORD_STEPS [8][6] = '{
    '{0, 0, 0, 0, 0, 0},
    '{-12, 12, 0, 0, 0, 0},
    '{4, 7, 12, 0, 0, 0},
    '{3, 7, 12, 0, 0, 0},
    '{7, 0, 0, 0, 0, 0},
    '{5, 7, 0, 0, 0, 0},
    '{-12, -24, 12, 24, 7, 19},
    '{0, 0, 0, 0, 0, 0}
  };
  localparam int CHORD_SIZE [8] = '{0, 2, 3, 3, 1, 2, 6, 0};

  logic [2:0]  chord_sel;
  logic [9:0]  spread_amt;
  logic        bypass_on;
  logic [2:0]  held_type [NOTE_SLOTS];
  midi_msg_t   stacked_msgs [$];
  int unsigned mismatches;

  // Appends every message that one input causes, in output order.
  task automatic stack_message(input logic [7:0] st, input logic [6:0] d1,
                               input logic [6:0] d2, input logic [15:0] t);
    logic [3:0]  ch;
    logic [10:0] key;
    logic        is_on;
    logic        is_off;
    logic [2:0]  ctype;
    int          note;
    int          ofs;
    int          r;
    int          num;
    int          vel;
    int unsigned seed;
    int unsigned jit;
    midi_msg_t   run [$];
    ch     = st[3:0];
    key    = {ch, d1};
    is_on  = (st[7:4] == MIDI_NOTE_ON) && (d2 != 7'd0);
    is_off = (st[7:4] == MIDI_NOTE_OFF) || ((st[7:4] == MIDI_NOTE_ON) && (d2 == 7'd0));
    run.push_back('{status: st, note: d1, vel: d2, stamp: {1'b0, t}, last: 1'b0});
    if (!bypass_on && (is_on || is_off)) begin
      ctype = chord_sel;
      if (is_on) begin
        if (int'(key) < NOTE_SLOTS) begin
          held_type[key] = (ctype == MCS_EMPTY_TYPE) ? 3'd0 : ctype;
        end
      end else if (int'(key) < NOTE_SLOTS) begin
        if (held_type[key] != MCS_EMPTY_TYPE) begin
          ctype = held_type[key];
        end
        held_type[key] = MCS_EMPTY_TYPE;
      end
      for (int i = 0; i < CHORD_SIZE[ctype]; i++) begin
        ofs  = CHORD_STEPS[ctype][i];
        note = int'(d1) + ofs;
        if (note >= 0 && note <= 127) begin
          if (is_on) begin
            // The seed wraps at 16 bits, so low notes with negative offsets go large.
            seed = (note * 13 + ofs * 7) & 32'hFFFF;
            r    = int'(seed % 100);
            vel  = int'(d2);
            jit  = 0;
            if (spread_amt != 10'd0) begin
              num = int'(spread_amt) * (2 * r - 100);
              vel = vel + num / 1280;
              jit = (r * spread_amt) >> 8;
              if (vel < 1) vel = 1;
              if (vel > 127) vel = 127;
            end
            run.push_back('{status: {MIDI_NOTE_ON, ch}, note: note[6:0], vel: vel[6:0],
                            stamp: 17'(t + jit), last: 1'b0});
          end else begin
            run.push_back('{status: {MIDI_NOTE_OFF, ch}, note: note[6:0], vel: 7'd0,
                            stamp: {1'b0, t}, last: 1'b0});
          end
        end
      end
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) stacked_msgs.push_back(run[i]);
  endtask

  task automatic report_mismatch(input midi_msg_t want, input logic have_want);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want) begin
        $display("%t: output mismatch: expected st=%h note=%0d vel=%0d t=%0d last=%b,",
                 $realtime, want.status, want.note, want.vel, want.stamp, want.last);
      end else begin
        $display("%t: output message with nothing expected,", $realtime);
      end
      $display("    got st=%h note=%0d vel=%0d t=%0d last=%b", out_status_i,
               out_data_one_i, out_data_two_i, out_time_i, last_of_run_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_sel  = 3'd0;
      spread_amt = 10'd0;
      bypass_on  = 1'b0;
      mismatches = 0;
      for (int i = 0; i < NOTE_SLOTS; i++) held_type[i] = MCS_EMPTY_TYPE;
      stacked_msgs.delete();
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHORD_TYPE: chord_sel  = cfg_wdata_i[2:0];
          CFG_SPREAD:     spread_amt = cfg_wdata_i;
          CFG_BYPASS:     bypass_on  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (stacked_msgs.size() == 0) begin
          report_mismatch('0, 1'b0);
        end else begin
          if (out_status_i !== stacked_msgs[0].status ||
              out_data_one_i !== stacked_msgs[0].note ||
              out_data_two_i !== stacked_msgs[0].vel ||
              out_time_i !== stacked_msgs[0].stamp ||
              last_of_run_i !== stacked_msgs[0].last) begin
            report_mismatch(stacked_msgs[0], 1'b1);
          end
          void'(stacked_msgs.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        stack_message(status_byte_i, data_one_i, data_two_i, sample_time_i);
      end
      mismatch_cnt_o <= mismatches;
      outstanding_o  <= stacked_msgs.size();
    end
  end

endmodule

// ===== test/midi_chord_stacker_top_tb.sv =====
// Top of the MIDI chord stacker testbench: clock, reset, register writes,
// directed and random MIDI traffic, output back-pressure and the verdict.
// Depends on mcs_pkg, midi_chord_stacker_top and mcs_stack_checker.
module midi_chord_stacker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcs_pkg::*;

  localparam int         QUIET_LIMIT  = 20000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         SEGMENTS     = 9;
  localparam int         SEG_ITEMS    = 17;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = 2'd0;
  logic [9:0]  cfg_wdata_i   = 10'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  status_byte_i = 8'd0;
  logic [6:0]  data_one_i    = 7'd0;
  logic [6:0]  data_two_i    = 7'd0;
  logic [15:0] sample_time_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  out_status_o;
  logic [6:0]  out_data_one_o;
  logic [6:0]  out_data_two_o;
  logic [16:0] out_time_o;
  logic        last_of_run_o;

  int unsigned mismatch_cnt;
  int unsigned outstanding;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 57;
  int unsigned msgs_in       = 0;
  int unsigned msgs_out      = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles  = 0;
  logic [10:0] held_keys [$];

  midi_chord_stacker_top dut (.*);

  mcs_stack_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .status_byte_i, .data_one_i,
    .data_two_i, .sample_time_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_status_i(out_status_o),
    .out_data_one_i(out_data_one_o), .out_data_two_i(out_data_two_o),
    .out_time_i(out_time_o), .last_of_run_i(last_of_run_o),
    .mismatch_cnt_o(mismatch_cnt), .outstanding_o(outstanding)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) msgs_out++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction happens.
  task automatic send_msg(input logic [7:0] st, input logic [6:0] d1,
                          input logic [6:0] d2, input logic [15:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    status_byte_i <= st;
    data_one_i    <= d1;
    data_two_i    <= d2;
    sample_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    msgs_in++;
  endtask

  // Holds the sender off until every predicted message has been taken.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Unused upper data bits and the spare index are randomized; both must be ignored.
  task automatic set_config(input logic [2:0] ctype, input logic [9:0] spr,
                            input logic byp);
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(CFG_CHORD_TYPE, {7'($urandom_range(127)), ctype});
    write_reg(CFG_SPREAD, spr);
    write_reg(CFG_BYPASS, {9'($urandom_range(511)), byp});
    write_reg(CFG_UNUSED, 10'($urandom_range(1023)));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 34;
        recv_idle_pct = 57;
      end
      1: begin
        send_idle_pct = 57;
        recv_idle_pct = 34;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Mostly note-on/note-off pairs on held keys, with some arbitrary messages.
  task automatic play_random_item();
    int          pick;
    int          idx;
    logic [10:0] key;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_msg(8'($urandom_range(255)), 7'($urandom_range(127)),
               7'($urandom_range(127)), 16'($urandom_range(65535)));
    end else if ((pick < 55 || held_keys.size() > 24) && held_keys.size() > 0) begin
      idx = $urandom_range(held_keys.size() - 1);
      key = held_keys[idx];
      held_keys.delete(idx);
      if ($urandom_range(1) == 1) begin
        send_msg({MIDI_NOTE_OFF, key[10:7]}, key[6:0], 7'($urandom_range(127)),
                 16'($urandom_range(65535)));
      end else begin
        send_msg({MIDI_NOTE_ON, key[10:7]}, key[6:0], 7'd0, 16'($urandom_range(65535)));
      end
    end else begin
      key = 11'($urandom_range(2047));
      held_keys.push_back(key);
      send_msg({MIDI_NOTE_ON, key[10:7]}, key[6:0], 7'($urandom_range(1, 127)),
               16'($urandom_range(65535)));
    end
  endtask

  initial begin
    logic [2:0] seg_type;
    logic [9:0] seg_spread;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // Widest chord and full spread: notes fall off both ends of the range.
    set_config(3'd6, 10'd1023, 1'b0);
    send_msg(8'h90, 7'd0, 7'd127, 16'hFFFF);
    send_msg(8'h9F, 7'd127, 7'd1, 16'h0000);
    send_msg(8'h93, 7'd60, 7'd64, 16'h1234);
    send_msg(8'h80, 7'd0, 7'd0, 16'h0010);
    send_msg(8'h9F, 7'd127, 7'd0, 16'h0020);
    send_msg(8'h85, 7'd60, 7'd127, 16'h0030);
    send_msg(8'h83, 7'd60, 7'd85, 16'hFFFF);
    send_msg(8'h00, 7'd127, 7'd127, 16'h0000);
    send_msg(8'hFF, 7'd0, 7'd0, 16'hFFFF);
    send_msg(8'hB3, 7'd7, 7'd100, 16'h0040);
    send_msg(8'h8F, 7'd127, 7'd127, 16'hFFFF);
    // Type seven plays the root alone and is remembered as root only.
    set_config(3'd7, 10'd1, 1'b0);
    send_msg(8'h92, 7'd64, 7'd100, 16'h0100);
    set_config(3'd2, 10'd512, 1'b0);
    send_msg(8'h82, 7'd64, 7'd0, 16'h0101);
    send_msg(8'h91, 7'd48, 7'd1, 16'h0102);
    send_msg(8'h91, 7'd49, 7'd127, 16'h0103);
    set_config(3'd3, 10'd300, 1'b1);
    send_msg(8'h94, 7'd60, 7'd64, 16'h0200);
    send_msg(8'h84, 7'd60, 7'd0, 16'h0201);
    send_msg(8'hC0, 7'd18, 7'd52, 16'h0202);
    set_config(3'd3, 10'd300, 1'b0);
    send_msg(8'h81, 7'd48, 7'd0, 16'h0300);
    send_msg(8'h91, 7'd49, 7'd0, 16'h0301);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: seg_type = 3'd6;
        1: seg_type = 3'd1;
        2: seg_type = 3'd2;
        3: seg_type = 3'd3;
        4: seg_type = 3'd4;
        5: seg_type = 3'd5;
        6: seg_type = 3'd0;
        7: seg_type = 3'd7;
        default: seg_type = 3'($urandom_range(7));
      endcase
      case (seg % 4)
        0: seg_spread = 10'd1023;
        1: seg_spread = 10'($urandom_range(1, 1022));
        2: seg_spread = 10'd0;
        default: seg_spread = 10'd1;
      endcase
      set_idling(seg / 3);
      set_config(seg_type, seg_spread, seg == 4);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ((seg == 1 || seg == 5) && n == SEG_ITEMS / 2) drain_outputs();
        play_random_item();
      end
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d input and %0d output messages over %0d register settings,",
             msgs_in, msgs_out, settings_used);
    $display("with both sides idling in turn and then running without gaps.");
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
